// File: hw/rtl/iso_ms_pkg.sv
// Shared types, character codes, calendar tables and constants for the
// ISO 8601 timestamp to epoch milliseconds core. No dependencies.
`default_nettype none

package iso_ms_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] PH_FIXED = 2'd0;
	localparam logic [1:0] PH_FRAC  = 2'd1;
	localparam logic [1:0] PH_DONE  = 2'd2;

	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_Z     = 8'h5A;

	localparam int MS_W         = 49;
	localparam int MS_PER_HOUR  = 3600000;
	localparam int MS_PER_MIN   = 60000;
	localparam int MS_PER_SEC   = 1000;
	localparam int MS_PER_DAY   = 86400000;
	localparam int DAYS_PER_ERA = 146097;
	localparam int DAY_SHIFT    = 719468;
	localparam int YEARS_PER_ERA = 400;
	localparam int ERA_RECIP    = 5243;
	localparam int ERA_SHIFT    = 21;

	typedef struct packed {
		logic        ok;
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
		logic [9:0]  frac;
	} job_t;

	function automatic logic [8:0] doy_base(input logic [3:0] mp);
		case (mp)
			4'd0:    doy_base = 9'd0;
			4'd1:    doy_base = 9'd31;
			4'd2:    doy_base = 9'd61;
			4'd3:    doy_base = 9'd92;
			4'd4:    doy_base = 9'd122;
			4'd5:    doy_base = 9'd153;
			4'd6:    doy_base = 9'd184;
			4'd7:    doy_base = 9'd214;
			4'd8:    doy_base = 9'd245;
			4'd9:    doy_base = 9'd275;
			4'd10:   doy_base = 9'd306;
			4'd11:   doy_base = 9'd337;
			default: doy_base = 9'd0;
		endcase
	endfunction

	function automatic logic [4:0] month_len(input logic [6:0] m);
		case (m)
			7'd1:    month_len = 5'd31;
			7'd2:    month_len = 5'd28;
			7'd3:    month_len = 5'd31;
			7'd4:    month_len = 5'd30;
			7'd5:    month_len = 5'd31;
			7'd6:    month_len = 5'd30;
			7'd7:    month_len = 5'd31;
			7'd8:    month_len = 5'd31;
			7'd9:    month_len = 5'd30;
			7'd10:   month_len = 5'd31;
			7'd11:   month_len = 5'd30;
			7'd12:   month_len = 5'd31;
			default: month_len = 5'd0;
		endcase
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/iso_ms_if.sv
// Valid/ready channel interfaces: character words in, result words out.
// Depends on nothing.
`default_nettype none

interface iso_ms_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       is_last;
	modport source(output valid, char_code, is_last, input ready);
	modport sink(input valid, char_code, is_last, output ready);
endinterface

interface iso_ms_res_if;
	logic               valid;
	logic               ready;
	logic               valid_res;
	logic signed [48:0] epoch_ms;
	modport source(output valid, valid_res, epoch_ms, input ready);
	modport sink(input valid, valid_res, epoch_ms, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/iso8601_utc_timestamp_to_epoch_ms_core.sv
// Top level: ISO 8601 UTC timestamp characters in, epoch milliseconds out.
// Depends on iso_ms_pkg, iso_ms_if, iso_ms_front, iso_ms_queue, iso_ms_back.
//
//   channel  dir  word                        end of word
//   chars    in   char_code[7:0], is_last     is_last = 1
//   result   out  valid_res, epoch_ms[48:0]   one word per string
//
// The parser takes one character per cycle while the job queue has room.
// Each string passes through the calculator sequencer (pop plus six steps);
// short strings sent back to back can outrun it, fill the queue and stall chars.
// A finished result waits in the output register while the next string parses.
// Reset clears parser, queue pointers, sequencer and output valid.
`default_nettype none

module iso8601_utc_timestamp_to_epoch_ms_core #(
	parameter int QUEUE_DEPTH = iso_ms_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	iso_ms_char_if.sink   chars,
	iso_ms_res_if.source  result
);

	logic             push;
	logic             full;
	logic             pop;
	logic             empty;
	iso_ms_pkg::job_t push_job;
	iso_ms_pkg::job_t head;

	iso_ms_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.push   (push),
		.job    (push_job),
		.full   (full)
	);

	iso_ms_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	iso_ms_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule

`default_nettype wire

// File: hw/rtl/iso_ms_front.sv
// Character parser: checks the fixed layout and fraction, accumulates fields,
// and pushes one job per string. Depends on iso_ms_pkg and iso_ms_char_if.
`default_nettype none

module iso_ms_front (
	input  logic                clk,
	input  logic                arst_n,
	iso_ms_char_if.sink         chars,
	output logic                push,
	output iso_ms_pkg::job_t    job,
	input  logic                full
);

	localparam logic [4:0] POS_DASH_A  = 5'd4;
	localparam logic [4:0] POS_DASH_B  = 5'd7;
	localparam logic [4:0] POS_T       = 5'd10;
	localparam logic [4:0] POS_COLON_A = 5'd13;
	localparam logic [4:0] POS_COLON_B = 5'd16;
	localparam logic [4:0] POS_END     = 5'd19;
	localparam logic [4:0] IDX_MAX     = 5'd31;

	logic [4:0]  idx_q, n_idx;
	logic [1:0]  phase_q, n_phase;
	logic [13:0] year_q, n_year;
	logic [6:0]  month_q, n_month;
	logic [6:0]  day_q, n_day;
	logic [6:0]  hour_q, n_hour;
	logic [6:0]  minute_q, n_minute;
	logic [6:0]  second_q, n_second;
	logic [9:0]  frac_q, n_frac;
	logic [1:0]  fcnt_q, n_fcnt;
	logic        failed_q, n_failed;
	logic        accept;
	logic        digit;
	logic [3:0]  v;
	logic [7:0]  c;
	logic [9:0]  frac_term;

	assign chars.ready = !full;
	assign accept = chars.valid && chars.ready;
	assign c = chars.char_code;
	assign digit = (c >= iso_ms_pkg::CH_0) && (c <= iso_ms_pkg::CH_9);
	assign v = c[3:0];

	always_comb begin
		case (fcnt_q)
			2'd0:    frac_term = 10'(v) * 10'd100;
			2'd1:    frac_term = 10'(v) * 10'd10;
			default: frac_term = 10'(v);
		endcase
	end

	always_comb begin
		n_idx = idx_q;
		n_phase = phase_q;
		n_year = year_q;
		n_month = month_q;
		n_day = day_q;
		n_hour = hour_q;
		n_minute = minute_q;
		n_second = second_q;
		n_frac = frac_q;
		n_fcnt = fcnt_q;
		n_failed = failed_q;
		if (!failed_q) begin
			case (phase_q)
				iso_ms_pkg::PH_FIXED: begin
					if (idx_q == POS_DASH_A || idx_q == POS_DASH_B) begin
						if (c != iso_ms_pkg::CH_DASH) n_failed = 1'b1;
					end else if (idx_q == POS_T) begin
						if (c != iso_ms_pkg::CH_T) n_failed = 1'b1;
					end else if (idx_q == POS_COLON_A || idx_q == POS_COLON_B) begin
						if (c != iso_ms_pkg::CH_COLON) n_failed = 1'b1;
					end else if (idx_q == POS_END) begin
						if (c == iso_ms_pkg::CH_DOT) n_phase = iso_ms_pkg::PH_FRAC;
						else if (c == iso_ms_pkg::CH_Z) n_phase = iso_ms_pkg::PH_DONE;
						else n_failed = 1'b1;
					end else if (!digit) begin
						n_failed = 1'b1;
					end else if (idx_q < POS_DASH_A) begin
						n_year = year_q * 14'd10 + 14'(v);
					end else if (idx_q < POS_DASH_B) begin
						n_month = month_q * 7'd10 + 7'(v);
					end else if (idx_q < POS_T) begin
						n_day = day_q * 7'd10 + 7'(v);
					end else if (idx_q < POS_COLON_A) begin
						n_hour = hour_q * 7'd10 + 7'(v);
					end else if (idx_q < POS_COLON_B) begin
						n_minute = minute_q * 7'd10 + 7'(v);
					end else begin
						n_second = second_q * 7'd10 + 7'(v);
					end
					if (idx_q != IDX_MAX) n_idx = idx_q + 5'd1;
				end
				iso_ms_pkg::PH_FRAC: begin
					if (digit) begin
						if (fcnt_q != 2'd3) begin
							n_frac = frac_q + frac_term;
							n_fcnt = fcnt_q + 2'd1;
						end
					end else if (c == iso_ms_pkg::CH_Z && fcnt_q != 2'd0) begin
						n_phase = iso_ms_pkg::PH_DONE;
					end else begin
						n_failed = 1'b1;
					end
				end
				default: n_failed = 1'b1;
			endcase
		end
	end

	assign push = accept && chars.is_last;

	always_comb begin
		job.ok = !n_failed && (n_phase == iso_ms_pkg::PH_DONE);
		job.year = n_year;
		job.month = n_month;
		job.day = n_day;
		job.hour = n_hour;
		job.minute = n_minute;
		job.second = n_second;
		job.frac = n_frac;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			phase_q <= iso_ms_pkg::PH_FIXED;
			year_q <= '0;
			month_q <= '0;
			day_q <= '0;
			hour_q <= '0;
			minute_q <= '0;
			second_q <= '0;
			frac_q <= '0;
			fcnt_q <= '0;
			failed_q <= 1'b0;
		end else if (accept) begin
			if (chars.is_last) begin
				idx_q <= '0;
				phase_q <= iso_ms_pkg::PH_FIXED;
				year_q <= '0;
				month_q <= '0;
				day_q <= '0;
				hour_q <= '0;
				minute_q <= '0;
				second_q <= '0;
				frac_q <= '0;
				fcnt_q <= '0;
				failed_q <= 1'b0;
			end else begin
				idx_q <= n_idx;
				phase_q <= n_phase;
				year_q <= n_year;
				month_q <= n_month;
				day_q <= n_day;
				hour_q <= n_hour;
				minute_q <= n_minute;
				second_q <= n_second;
				frac_q <= n_frac;
				fcnt_q <= n_fcnt;
				failed_q <= n_failed;
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/iso_ms_queue.sv
// Short job queue between parser and calculator, held in registers.
// Depends on iso_ms_pkg.
`default_nettype none

module iso_ms_queue #(
	parameter int DEPTH = iso_ms_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  iso_ms_pkg::job_t push_job,
	output logic             full,
	input  logic             pop,
	output iso_ms_pkg::job_t head,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	iso_ms_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (pop) rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			if (push && !pop) cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("pop from empty queue");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("queue count did not advance on push");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/iso_ms_back.sv
// Calculator: range and calendar checks, day count and millisecond sum over a
// short sequence, with an output register. Depends on iso_ms_pkg, iso_ms_res_if.
`default_nettype none

module iso_ms_back (
	input  logic             clk,
	input  logic             arst_n,
	input  iso_ms_pkg::job_t head,
	input  logic             empty,
	output logic             pop,
	iso_ms_res_if.source     result
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_S1   = 3'd1;
	localparam logic [2:0] ST_S2   = 3'd2;
	localparam logic [2:0] ST_S3   = 3'd3;
	localparam logic [2:0] ST_S4   = 3'd4;
	localparam logic [2:0] ST_S5   = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	localparam logic signed [27:0] MS_DAY_S = 28'(iso_ms_pkg::MS_PER_DAY);
	localparam logic [23:0] DAY_OFS = 24'(iso_ms_pkg::DAY_SHIFT + iso_ms_pkg::DAYS_PER_ERA);

	logic [2:0]         st_q;
	iso_ms_pkg::job_t   job_q;
	logic [13:0]        y2_q;
	logic               early_q;
	logic [4:0]         era_q;
	logic [28:0]        tod_a_q;
	logic [28:0]        tod_q;
	logic [8:0]         yoe_q;
	logic [8:0]         doy_q;
	logic               range_ok_q;
	logic               ok_q;
	logic [17:0]        doe_q;
	logic [21:0]        eraday_q;
	logic signed [23:0] days_q;
	logic signed [48:0] dms_q;
	logic               valid_q;
	logic               res_ok_q;
	logic signed [48:0] res_ms_q;

	logic               early;
	logic [13:0]        y2;
	logic [26:0]        prod;
	logic [3:0]         mp;
	logic [8:0]         r400;
	logic               leap;
	logic [4:0]         mdays;
	logic [1:0]         cent;
	logic               out_free;
	logic signed [48:0] sum;

	assign pop = (st_q == ST_IDLE) && !empty;
	assign out_free = !valid_q || result.ready;

	assign early = (job_q.month <= 7'd2);
	assign y2 = job_q.year + 14'(iso_ms_pkg::YEARS_PER_ERA) - {13'd0, early};
	assign prod = 27'(y2) * 27'(iso_ms_pkg::ERA_RECIP);
	assign mp = (job_q.month > 7'd2) ? 4'(job_q.month - 7'd3) : 4'(job_q.month + 7'd9);

	always_comb begin
		if (early_q) r400 = (yoe_q == 9'd399) ? 9'd0 : yoe_q + 9'd1;
		else r400 = yoe_q;
		leap = (r400[1:0] == 2'd0) && (r400 != 9'd100) && (r400 != 9'd200)
			&& (r400 != 9'd300);
		mdays = iso_ms_pkg::month_len(job_q.month);
		if (job_q.month == 7'd2 && leap) mdays = 5'd29;
		if (yoe_q >= 9'd300) cent = 2'd3;
		else if (yoe_q >= 9'd200) cent = 2'd2;
		else if (yoe_q >= 9'd100) cent = 2'd1;
		else cent = 2'd0;
	end

	assign sum = dms_q + 49'(tod_q);

	always_ff @(posedge clk) begin
		if (pop) job_q <= head;
		if (st_q == ST_S1) begin
			y2_q <= y2;
			early_q <= early;
			era_q <= prod[iso_ms_pkg::ERA_SHIFT+4:iso_ms_pkg::ERA_SHIFT];
			tod_a_q <= 29'(job_q.hour) * 29'(iso_ms_pkg::MS_PER_HOUR)
				+ 29'(job_q.minute) * 29'(iso_ms_pkg::MS_PER_MIN);
		end
		if (st_q == ST_S2) begin
			yoe_q <= 9'(y2_q - 14'(era_q) * 14'(iso_ms_pkg::YEARS_PER_ERA));
			doy_q <= iso_ms_pkg::doy_base(mp) + 9'(job_q.day) - 9'd1;
			tod_q <= tod_a_q + 29'(job_q.second) * 29'(iso_ms_pkg::MS_PER_SEC)
				+ 29'(job_q.frac);
			range_ok_q <= job_q.ok && (job_q.month >= 7'd1) && (job_q.month <= 7'd12)
				&& (job_q.day >= 7'd1) && (job_q.hour <= 7'd23)
				&& (job_q.minute <= 7'd59) && (job_q.second <= 7'd59);
		end
		if (st_q == ST_S3) begin
			ok_q <= range_ok_q && (job_q.day <= 7'(mdays));
			doe_q <= 18'(yoe_q) * 18'd365 + 18'(yoe_q >> 2) - 18'(cent) + 18'(doy_q);
			eraday_q <= 22'(era_q) * 22'(iso_ms_pkg::DAYS_PER_ERA);
		end
		if (st_q == ST_S4) begin
			days_q <= 24'(eraday_q) + 24'(doe_q) - DAY_OFS;
		end
		if (st_q == ST_S5) begin
			dms_q <= 49'(days_q) * 49'(MS_DAY_S);
		end
		if (st_q == ST_OUT && out_free) begin
			res_ok_q <= ok_q;
			res_ms_q <= ok_q ? sum : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: if (pop) st_q <= ST_S1;
				ST_S1:   st_q <= ST_S2;
				ST_S2:   st_q <= ST_S3;
				ST_S3:   st_q <= ST_S4;
				ST_S4:   st_q <= ST_S5;
				ST_S5:   st_q <= ST_OUT;
				ST_OUT:  if (out_free) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
			if (st_q == ST_OUT && out_free) valid_q <= 1'b1;
			else if (result.ready) valid_q <= 1'b0;
		end
	end

	assign result.valid = valid_q;
	assign result.valid_res = res_ok_q;
	assign result.epoch_ms = res_ms_q;

`ifndef SYNTHESIS
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.valid_res |-> result.epoch_ms == '0)
		else $error("invalid result carries nonzero time");
	a_load_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_q) |-> $past(st_q) == ST_OUT)
		else $error("result loaded outside output step");
	a_pop_starts: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> st_q == ST_S1)
		else $error("popped job did not start");
`endif

endmodule

`default_nettype wire

// File: verif/iso8601_utc_timestamp_to_epoch_ms_core_scoreboard.sv
// Scoreboard for the ISO 8601 timestamp to epoch milliseconds core: watches the
// character and result channels, predicts each result and compares it.
// Depends on iso_ms_pkg and iso_ms_if.
`default_nettype none

module iso8601_utc_timestamp_to_epoch_ms_core_scoreboard (
	input  logic   clk,
	input  logic   arst_n,
	iso_ms_char_if chars,
	iso_ms_res_if  result,
	output int     fail_count,
	output int     pending
);

	localparam int POS_DASH1  = 4;
	localparam int POS_DASH2  = 7;
	localparam int POS_T      = 10;
	localparam int POS_COLON1 = 13;
	localparam int POS_COLON2 = 16;
	localparam int POS_SUFFIX = 19;
	localparam int POS_MAX    = 31;

	typedef struct {
		logic                               ok;
		logic signed [iso_ms_pkg::MS_W-1:0] ms;
	} stamp_t;

	stamp_t      stamp_q[$];
	stamp_t      want;
	int          fails = 0;

	logic [4:0]  fixed_pos;
	logic [1:0]  parse_phase;
	logic [13:0] year_val;
	logic [6:0]  month_val;
	logic [6:0]  day_val;
	logic [6:0]  hour_val;
	logic [6:0]  minute_val;
	logic [6:0]  second_val;
	logic [9:0]  frac_val;
	logic [1:0]  frac_count;
	logic        broken;

	initial begin
		fail_count = 0;
		pending = 0;
	end

	function automatic bit is_leap(input int y);
		return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
	endfunction

	function automatic int month_day_count(input int y, input int m);
		case (m)
			2:           return is_leap(y) ? 29 : 28;
			4, 6, 9, 11: return 30;
			default:     return 31;
		endcase
	endfunction

	function automatic longint civil_days(input int y_in, input int m, input int d);
		longint y;
		longint era;
		longint yoe;
		longint doy;
		longint doe;
		y = y_in;
		if (m <= 2)
			y = y - 1;
		era = (y >= 0 ? y : y - (iso_ms_pkg::YEARS_PER_ERA - 1)) / iso_ms_pkg::YEARS_PER_ERA;
		yoe = y - era * iso_ms_pkg::YEARS_PER_ERA;
		doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
		doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		return era * iso_ms_pkg::DAYS_PER_ERA + doe - iso_ms_pkg::DAY_SHIFT;
	endfunction

	task automatic clear_parse();
		fixed_pos   = '0;
		parse_phase = iso_ms_pkg::PH_FIXED;
		year_val    = '0;
		month_val   = '0;
		day_val     = '0;
		hour_val    = '0;
		minute_val  = '0;
		second_val  = '0;
		frac_val    = '0;
		frac_count  = '0;
		broken      = 1'b0;
	endtask

	task automatic take_fixed(input logic [7:0] c);
		logic       digit;
		logic [3:0] v;
		int         p;
		digit = (c >= iso_ms_pkg::CH_0) && (c <= iso_ms_pkg::CH_9);
		v = 4'(c - iso_ms_pkg::CH_0);
		p = fixed_pos;
		if (p == POS_DASH1 || p == POS_DASH2) begin
			if (c != iso_ms_pkg::CH_DASH)
				broken = 1'b1;
		end else if (p == POS_T) begin
			if (c != iso_ms_pkg::CH_T)
				broken = 1'b1;
		end else if (p == POS_COLON1 || p == POS_COLON2) begin
			if (c != iso_ms_pkg::CH_COLON)
				broken = 1'b1;
		end else if (p == POS_SUFFIX) begin
			if (c == iso_ms_pkg::CH_DOT)
				parse_phase = iso_ms_pkg::PH_FRAC;
			else if (c == iso_ms_pkg::CH_Z)
				parse_phase = iso_ms_pkg::PH_DONE;
			else
				broken = 1'b1;
		end else if (!digit) begin
			broken = 1'b1;
		end else if (p < POS_DASH1) begin
			year_val = year_val * 14'd10 + 14'(v);
		end else if (p < POS_DASH2) begin
			month_val = month_val * 7'd10 + 7'(v);
		end else if (p < POS_T) begin
			day_val = day_val * 7'd10 + 7'(v);
		end else if (p < POS_COLON1) begin
			hour_val = hour_val * 7'd10 + 7'(v);
		end else if (p < POS_COLON2) begin
			minute_val = minute_val * 7'd10 + 7'(v);
		end else begin
			second_val = second_val * 7'd10 + 7'(v);
		end
	endtask

	task automatic absorb_char(input logic [7:0] c);
		logic [3:0] v;
		v = 4'(c - iso_ms_pkg::CH_0);
		if (!broken) begin
			case (parse_phase)
				iso_ms_pkg::PH_FIXED: begin
					take_fixed(c);
					if (fixed_pos != 5'(POS_MAX))
						fixed_pos = fixed_pos + 5'd1;
				end
				iso_ms_pkg::PH_FRAC: begin
					if (c >= iso_ms_pkg::CH_0 && c <= iso_ms_pkg::CH_9) begin
						if (frac_count != 2'd3) begin
							case (frac_count)
								2'd0:    frac_val = frac_val + 10'(v) * 10'd100;
								2'd1:    frac_val = frac_val + 10'(v) * 10'd10;
								default: frac_val = frac_val + 10'(v);
							endcase
							frac_count = frac_count + 2'd1;
						end
					end else if (c == iso_ms_pkg::CH_Z && frac_count != 2'd0) begin
						parse_phase = iso_ms_pkg::PH_DONE;
					end else begin
						broken = 1'b1;
					end
				end
				default: broken = 1'b1;
			endcase
		end
	endtask

	task automatic close_stamp();
		stamp_t item;
		longint ms;
		int     yr, mo, dy, hr, mi, se, fr;
		yr = year_val;
		mo = month_val;
		dy = day_val;
		hr = hour_val;
		mi = minute_val;
		se = second_val;
		fr = frac_val;
		item.ok = !broken && parse_phase == iso_ms_pkg::PH_DONE;
		if (item.ok && (mo < 1 || mo > 12))
			item.ok = 1'b0;
		if (item.ok && (dy < 1 || dy > month_day_count(yr, mo)))
			item.ok = 1'b0;
		if (item.ok && (hr > 23 || mi > 59 || se > 59))
			item.ok = 1'b0;
		ms = 0;
		if (item.ok)
			ms = (civil_days(yr, mo, dy) * 86400 + hr * 3600 + mi * 60 + se)
				* iso_ms_pkg::MS_PER_SEC + fr;
		item.ms = ms[iso_ms_pkg::MS_W-1:0];
		stamp_q.push_back(item);
		clear_parse();
	endtask

	initial clear_parse();

	always @(posedge clk) begin
		if (arst_n) begin
			if (chars.valid && chars.ready) begin
				absorb_char(chars.char_code);
				if (chars.is_last)
					close_stamp();
			end
			if (result.valid && result.ready) begin
				if (stamp_q.size() == 0) begin
					$display("%0t: unexpected result word: valid_res=%0b epoch_ms=%0d",
						$time, result.valid_res, result.epoch_ms);
					fails++;
				end else begin
					want = stamp_q.pop_front();
					if (want.ok !== result.valid_res) begin
						$display("%0t: valid_res mismatch: expected %0b, got %0b",
							$time, want.ok, result.valid_res);
						fails++;
					end
					if (want.ms !== result.epoch_ms) begin
						$display("%0t: epoch_ms mismatch: expected %0d, got %0d",
							$time, want.ms, result.epoch_ms);
						fails++;
					end
				end
			end
			fail_count <= fails;
			pending <= stamp_q.size();
		end
	end

endmodule

`default_nettype wire

// File: verif/iso8601_utc_timestamp_to_epoch_ms_core_tb.sv
// Testbench top for the ISO 8601 timestamp to epoch milliseconds core: drives
// timestamp strings and result back-pressure, and reports the verdict.
// Depends on iso_ms_pkg, iso_ms_if, the core and its scoreboard.
`default_nettype none

module iso8601_utc_timestamp_to_epoch_ms_core_tb;

	localparam int MAX_GAP        = 17;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 20;
	localparam int RANDOM_CHARS   = 560;
	localparam int RANDOM_STRINGS = 20;

	logic       clk = 1'b0;
	logic       arst_n;
	int         fail_count;
	int         pending;
	int         char_gap_max = 0;
	int         result_gap_max = 0;
	bit         hold_req = 1'b0;
	int         chars_sent = 0;
	int         strings_sent = 0;
	logic [7:0] line_q[$];

	iso_ms_char_if chars();
	iso_ms_res_if  result();

	iso8601_utc_timestamp_to_epoch_ms_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.result (result)
	);

	iso8601_utc_timestamp_to_epoch_ms_core_scoreboard u_scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.chars      (chars),
		.result     (result),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	initial begin
		#5000000;
		$display("iso8601_utc_timestamp_to_epoch_ms_core test failed");
		$finish;
	end

	function automatic int draw_gap(input int max_gap);
		return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, max_gap);
	endfunction

	function automatic int pick_gap_max();
		case ($urandom_range(0, 2))
			0:       return 0;
			1:       return 3;
			default: return MAX_GAP;
		endcase
	endfunction

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_q.push_back(s[i]);
	endtask

	task automatic push_num(input int value, input int digits);
		int div;
		div = 1;
		repeat (digits - 1) div *= 10;
		repeat (digits) begin
			line_q.push_back(iso_ms_pkg::CH_0 + 8'((value / div) % 10));
			div /= 10;
		end
	endtask

	task automatic send_char(input logic [7:0] c, input logic last);
		int gap;
		gap = draw_gap(char_gap_max);
		if (gap > 0) begin
			chars.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars.valid <= 1'b1;
		chars.char_code <= c;
		chars.is_last <= last;
		do @(posedge clk); while (!chars.ready);
		chars_sent++;
	endtask

	task automatic send_line();
		for (int i = 0; i < line_q.size(); i++)
			send_char(line_q[i], i == line_q.size() - 1);
		line_q.delete();
		strings_sent++;
	endtask

	task automatic send_text(input string s);
		push_text(s);
		send_line();
	endtask

	task automatic wait_drained();
		chars.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic push_random_stamp();
		int yr, mo, dy, hr, mi, se, nfrac, cut;
		yr = $urandom_range(0, 9999);
		mo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
		case ($urandom_range(0, 9))
			0:       dy = $urandom_range(0, 99);
			1, 2:    dy = $urandom_range(28, 31);
			default: dy = $urandom_range(1, 28);
		endcase
		if ($urandom_range(0, 7) == 0) begin
			mo = 2;
			dy = $urandom_range(28, 29);
			yr = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 99) * 100 : yr;
		end
		hr = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 99) : $urandom_range(0, 23);
		mi = ($urandom_range(0, 9) == 0) ? $urandom_range(55, 99) : $urandom_range(0, 59);
		se = ($urandom_range(0, 9) == 0) ? $urandom_range(55, 99) : $urandom_range(0, 59);
		push_num(yr, 4);
		push_text("-");
		push_num(mo, 2);
		push_text("-");
		push_num(dy, 2);
		push_text("T");
		push_num(hr, 2);
		push_text(":");
		push_num(mi, 2);
		push_text(":");
		push_num(se, 2);
		case ($urandom_range(0, 3))
			2: begin
				push_text(".");
				push_num($urandom_range(0, 999), $urandom_range(1, 3));
			end
			3: begin
				push_text(".");
				nfrac = $urandom_range(0, 8);
				repeat (nfrac)
					line_q.push_back(iso_ms_pkg::CH_0 + 8'($urandom_range(0, 9)));
			end
			default: ;
		endcase
		push_text("Z");
		case ($urandom_range(0, 19))
			0, 1: line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
			2:    repeat ($urandom_range(1, 3)) line_q.push_back(8'($urandom_range(0, 255)));
			3: begin
				cut = $urandom_range(1, line_q.size() - 1);
				while (line_q.size() > cut) void'(line_q.pop_back());
			end
			default: ;
		endcase
	endtask

	initial begin : result_drain
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				result.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				gap = draw_gap(result_gap_max);
				if (gap > 0) begin
					result.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (!result.valid);
		end
	end

	initial begin
		chars.valid <= 1'b0;
		chars.char_code <= '0;
		chars.is_last <= 1'b0;
		result.ready <= 1'b0;
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		send_text("1970-01-01T00:00:00Z");
		send_text("0000-01-01T00:00:00Z");
		send_text("9999-12-31T23:59:59.999Z");
		char_gap_max = MAX_GAP;
		result_gap_max = MAX_GAP;
		send_text("0000-02-29T23:59:59.5Z");
		send_text("2000-02-29T12:34:56.7Z");
		send_text("1900-02-29T00:00:00Z");
		send_text("2024-13-01T00:00:00Z");
		send_text("2023-06-15T24:00:00Z");
		send_text("2023-06-15T10:60:59Z");
		send_text("2021-04-05T06:07:08.Z");
		send_text("2021-04-05T06:07:08.123456Z");
		send_text("2021-04-05T06:07:08ZZ");
		send_text("2021-04-05T06:07:08");
		send_text("2021/04-05T06:07:08Z");
		send_text("Z");
		line_q.push_back(8'h00);
		line_q.push_back(8'hFF);
		send_line();

		// fill the block while results are held off
		wait_drained();
		hold_req = 1'b1;
		char_gap_max = 0;
		repeat (6) begin
			send_text("Z");
			send_text("1970Z");
		end
		wait_drained();

		chars_sent = 0;
		strings_sent = 0;
		while (chars_sent < RANDOM_CHARS || strings_sent < RANDOM_STRINGS) begin
			if (strings_sent % 10 == 0) begin
				char_gap_max = pick_gap_max();
				result_gap_max = pick_gap_max();
			end
			if (strings_sent == RANDOM_STRINGS / 2)
				wait_drained();
			if ($urandom_range(0, 99) < 80) begin
				push_random_stamp();
			end else begin
				repeat ($urandom_range(1, 30)) line_q.push_back(8'($urandom_range(0, 255)));
			end
			send_line();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("iso8601_utc_timestamp_to_epoch_ms_core test passed");
		else
			$display("iso8601_utc_timestamp_to_epoch_ms_core test failed");
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/iso_ms_pkg.sv
hw/rtl/iso_ms_if.sv
hw/rtl/iso_ms_front.sv
hw/rtl/iso_ms_queue.sv
hw/rtl/iso_ms_back.sv
hw/rtl/iso8601_utc_timestamp_to_epoch_ms_core.sv
verif/iso8601_utc_timestamp_to_epoch_ms_core_scoreboard.sv
verif/iso8601_utc_timestamp_to_epoch_ms_core_tb.sv
